### hdl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// implication whose consequent is checked in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next cycle check failed");

`endif

### hdl/tshc_pkg.sv
// shared types, constants and helpers of the slope heatmap color block
`timescale 1ns / 1ps

package tshc_pkg;

    localparam int HW = 20;                 // corner height width
    localparam int GW = 24;                 // grade width
    localparam int CW = 32;                 // argb width
    localparam int TILE_SIZE_DEF = 16;

    localparam logic [GW-1:0] GRADE_MAX = 24'hFFFFFF;

    localparam logic [10:0] EDGE_MUL  = 11'd1600;       // percent * 256 / 16, edge scale
    localparam logic [26:0] DIAG_MUL  = 27'd74145600;   // 1600 * 46341
    localparam logic [19:0] PLANE_MUL = 20'd640000;     // 1600 squared / 4
    localparam logic [12:0] TOP_ADD   = 13'd7680;

    // isqrt of a 64-bit value, two bits per step
    localparam int ISQ_STEPS  = 4;
    localparam int ISQ_STAGES = 8;

    // smoothstep weight division, one quotient bit per step
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = 4;

    localparam int GRADE_LAT = 4 + ISQ_STAGES + 2;
    localparam int RAMP_LAT  = 1 + DIV_STAGES + 3;

    // register indexes of the config port
    localparam logic [2:0] REG_GRADE_MODE  = 3'd0;
    localparam logic [2:0] REG_MIN_GRADE   = 3'd1;
    localparam logic [2:0] REG_ALPHA_LEVEL = 3'd2;
    localparam logic [2:0] REG_BAND_EDGE_0 = 3'd3;
    localparam logic [2:0] REG_BAND_EDGE_1 = 3'd4;
    localparam logic [2:0] REG_BAND_EDGE_2 = 3'd5;
    localparam logic [2:0] REG_BAND_EDGE_3 = 3'd6;

    typedef struct packed {
        logic [GW-1:0]        min_grade;
        logic [7:0]           alpha_level;
        logic [3:0][GW-1:0]   band_edge;
    } tshc_cfg_t;

    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
        logic [63:0] q;
    } isq_state_t;

    typedef struct packed {
        logic [25:0] rem;
        logic [25:0] dv;
        logic [15:0] quot;
        logic        one;
        logic        zero;
    } div_state_t;

    typedef struct packed {
        logic          shown;
        logic [2:0]    band;
        logic [GW-1:0] grade;
    } side_t;

    // six-color ramp, low grade to high grade
    function automatic logic [23:0] ramp_color(input logic [2:0] idx);
        logic [23:0] c;
        unique case (idx)
            3'd0:    c = 24'h4CA46D;
            3'd1:    c = 24'h9CCB5B;
            3'd2:    c = 24'hE9C85B;
            3'd3:    c = 24'hE69A43;
            3'd4:    c = 24'hD85A3F;
            3'd5:    c = 24'h9A3D68;
            default: c = 24'h000000;
        endcase
        return c;
    endfunction

endpackage

### hdl/tshc_grade.sv
// grade pipeline: edge and diagonal maxima, plane isqrt, divide by tile size
`timescale 1ns / 1ps

module tshc_grade
    import tshc_pkg::*;
#(
    parameter int TILE_SIZE = TILE_SIZE_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [3:0][HW-1:0]   heights,
    input  logic                 grade_mode,
    output logic                 out_valid,
    output logic [GW-1:0]        grade
);

    localparam int TW = $clog2(TILE_SIZE + 1);
    localparam logic [TW-1:0] TILE = TW'(TILE_SIZE);
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / 64'(TILE_SIZE));

    function automatic logic [HW:0] abs_diff(input logic [HW:0] a, input logic [HW:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic isq_state_t isq_steps(input isq_state_t st);
        isq_state_t s;
        logic [35:0] cur;
        logic [35:0] trial;
        s = st;
        for (int i = 0; i < ISQ_STEPS; i++) begin
            cur   = {s.rem, s.q[63:62]};
            trial = {2'b00, s.root, 2'b01};
            s.q   = {s.q[61:0], 2'b00};
            if (cur >= trial) begin
                s.rem  = 34'(cur - trial);
                s.root = {s.root[30:0], 1'b1};
            end
            else begin
                s.rem  = cur[33:0];
                s.root = {s.root[30:0], 1'b0};
            end
        end
        return s;
    endfunction

    logic [GRADE_LAT-1:0] vld_reg;

    logic [HW-1:0] d_reg [4];
    logic [HW-1:0] dd_reg [2];
    logic [HW:0]   dx_reg, dz_reg;
    logic [HW-1:0] me_reg, md_reg;
    logic [41:0]   dx2_reg, dz2_reg;
    logic [30:0]   xe_reg;
    logic [46:0]   yd_reg;
    logic [42:0]   p_reg;
    logic [30:0]   m0_reg;
    logic [63:0]   q_reg;
    isq_state_t    isq_reg [ISQ_STAGES];
    logic [30:0]   m0c_reg [ISQ_STAGES];
    logic [31:0]   q0_reg, sel_reg;
    logic [GW-1:0] grade_reg;

    logic [HW:0]   h00, h10, h01, h11;
    logic [HW-1:0] me_next, md_next;
    logic [30:0]   zd_next;
    logic [31:0]   sel_next;
    logic [64:0]   prod_next;
    logic [40:0]   qt_next;
    logic [32:0]   rm_next, qc_next;
    logic [GW-1:0] grade_next;

    assign h00 = {1'b0, heights[0]};
    assign h10 = {1'b0, heights[1]};
    assign h01 = {1'b0, heights[2]};
    assign h11 = {1'b0, heights[3]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[GRADE_LAT-2:0], in_valid};
        end
    end

    // edge and diagonal height steps, plane slopes
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0]  <= HW'(abs_diff(h10, h00));
            d_reg[1]  <= HW'(abs_diff(h11, h10));
            d_reg[2]  <= HW'(abs_diff(h11, h01));
            d_reg[3]  <= HW'(abs_diff(h01, h00));
            dd_reg[0] <= HW'(abs_diff(h11, h00));
            dd_reg[1] <= HW'(abs_diff(h10, h01));
            dx_reg    <= abs_diff(h10 + h11, h00 + h01);
            dz_reg    <= abs_diff(h01 + h11, h00 + h10);
        end
    end

    always_comb
    begin
        me_next = d_reg[0];
        for (int i = 1; i < 4; i++)
        begin
            if (d_reg[i] > me_next)
            begin
                me_next = d_reg[i];
            end
        end
        md_next = (dd_reg[1] > dd_reg[0]) ? dd_reg[1] : dd_reg[0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            me_reg  <= me_next;
            md_reg  <= md_next;
            dx2_reg <= 42'(dx_reg) * 42'(dx_reg);
            dz2_reg <= 42'(dz_reg) * 42'(dz_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xe_reg <= 31'(31'(me_reg) * 31'(EDGE_MUL));
            yd_reg <= 47'(47'(md_reg) * 47'(DIAG_MUL));
            p_reg  <= 43'(dx2_reg) + 43'(dz2_reg);
        end
    end

    // floor of max over scaled steps commutes with the final divide
    assign zd_next = yd_reg[46:16];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m0_reg <= (zd_next > xe_reg) ? zd_next : xe_reg;
            q_reg  <= 64'(64'(p_reg) * 64'(PLANE_MUL));
        end
    end

    for (genvar k = 0; k < ISQ_STAGES; k++)
    begin : g_isq
        isq_state_t  st_in;
        logic [30:0] m0_in;
        if (k == 0)
        begin : g_first
            assign st_in = '{rem: '0, root: '0, q: q_reg};
            assign m0_in = m0_reg;
        end
        else
        begin : g_rest
            assign st_in = isq_reg[k-1];
            assign m0_in = m0c_reg[k-1];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                isq_reg[k] <= isq_steps(st_in);
                m0c_reg[k] <= m0_in;
            end
        end
    end

    // divide by tile size: reciprocal estimate, then one correction
    assign sel_next  = grade_mode ? isq_reg[ISQ_STAGES-1].root
                                  : {1'b0, m0c_reg[ISQ_STAGES-1]};
    assign prod_next = 65'(sel_next) * 65'(RECIP);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q0_reg  <= prod_next[63:32];
            sel_reg <= sel_next;
        end
    end

    always_comb
    begin
        qt_next = 41'(q0_reg) * 41'(TILE);
        rm_next = {1'b0, sel_reg} - qt_next[32:0];
        qc_next = {1'b0, q0_reg} + 33'(rm_next >= 33'(TILE));
        grade_next = (qc_next > 33'(GRADE_MAX)) ? GRADE_MAX : qc_next[GW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            grade_reg <= grade_next;
        end
    end

    assign out_valid = vld_reg[GRADE_LAT-1];
    assign grade     = grade_reg;

endmodule

### hdl/tshc_ramp.sv
// color pipeline: band select, smoothstep weight, channel blend
`timescale 1ns / 1ps

module tshc_ramp
    import tshc_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [GW-1:0]  grade,
    input  tshc_cfg_t      cfg,
    output logic           out_valid,
    output logic           shown,
    output logic [GW-1:0]  grade_out,
    output logic [CW-1:0]  color
);

    function automatic div_state_t div_steps(input div_state_t st);
        div_state_t s;
        logic [26:0] cur;
        s = st;
        for (int i = 0; i < DIV_STEPS; i++) begin
            cur = {s.rem, 1'b0};
            if (cur >= {1'b0, s.dv}) begin
                s.rem  = 26'(cur - {1'b0, s.dv});
                s.quot = {s.quot[14:0], 1'b1};
            end
            else begin
                s.rem  = cur[25:0];
                s.quot = {s.quot[14:0], 1'b0};
            end
        end
        return s;
    endfunction

    function automatic logic [7:0] blend(input logic [7:0] ca, input logic [7:0] cb,
                                         input logic [16:0] s);
        logic [7:0]  mag;
        logic [24:0] p;
        logic [24:0] pr;
        logic [9:0]  r;
        mag = (cb >= ca) ? cb - ca : ca - cb;
        p   = 25'(mag) * 25'(s);
        pr  = p + 25'd32768;
        if (cb >= ca) begin
            r = {2'b00, ca} + {1'b0, pr[24:16]};
            return (r > 10'd255) ? 8'hFF : r[7:0];
        end
        else begin
            r = {2'b00, ca} - {1'b0, pr[24:16]};
            return ({1'b0, pr[24:16]} > {2'b00, ca}) ? 8'h00 : r[7:0];
        end
    endfunction

    logic [RAMP_LAT-1:0] vld_reg;
    side_t               side_reg [RAMP_LAT];
    div_state_t          div_reg [DIV_STAGES+1];
    logic [33:0]         t2_reg;
    logic [17:0]         poly_reg;
    logic [16:0]         s_reg;
    logic [CW-1:0]       color_reg;

    logic [25:0] g26, e0, e1, e2, e3, top_a, top_b, top, lo, hi;
    logic [26:0] e3x5;
    logic [2:0]  band_next;
    logic        shown_next, full_next;
    logic [16:0] t_next;
    logic [51:0] prod_next;
    logic [2:0]  bnd;
    logic [23:0] ca, cb, rgb_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[RAMP_LAT-2:0], in_valid};
        end
    end

    // band select on grade
    always_comb
    begin
        g26   = 26'(grade);
        e0    = 26'(cfg.band_edge[0]);
        e1    = 26'(cfg.band_edge[1]);
        e2    = 26'(cfg.band_edge[2]);
        e3    = 26'(cfg.band_edge[3]);
        top_a = e3 + 26'(TOP_ADD);
        e3x5  = 27'(e3) * 27'd5;
        top_b = e3x5[26:1];
        top   = (top_a > top_b) ? top_a : top_b;
        priority if (g26 <= e0)
        begin
            band_next = 3'd0; lo = 26'(cfg.min_grade); hi = e0;
        end
        else if (g26 <= e1)
        begin
            band_next = 3'd1; lo = e0; hi = e1;
        end
        else if (g26 <= e2)
        begin
            band_next = 3'd2; lo = e1; hi = e2;
        end
        else if (g26 <= e3)
        begin
            band_next = 3'd3; lo = e2; hi = e3;
        end
        else
        begin
            band_next = 3'd4; lo = e3; hi = top;
        end
        shown_next = grade >= cfg.min_grade;
        full_next  = g26 >= hi;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= '{shown: shown_next, band: band_next, grade: grade};
            // degenerate band steps to full weight only at or past its top
            div_reg[0]  <= '{rem: g26 - lo, dv: hi - lo, quot: '0,
                             one: full_next, zero: (hi <= lo) && !full_next};
        end
    end

    for (genvar k = 1; k < RAMP_LAT; k++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    for (genvar k = 1; k <= DIV_STAGES; k++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_reg[k] <= div_steps(div_reg[k-1]);
            end
        end
    end

    // smoothstep in q16: t*t*(3 - 2t)
    always_comb
    begin
        priority if (div_reg[DIV_STAGES].one)
        begin
            t_next = 17'd65536;
        end
        else if (div_reg[DIV_STAGES].zero)
        begin
            t_next = '0;
        end
        else
        begin
            t_next = {1'b0, div_reg[DIV_STAGES].quot};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t2_reg   <= 34'(t_next) * 34'(t_next);
            poly_reg <= 18'd196608 - {t_next, 1'b0};
        end
    end

    assign prod_next = 52'(t2_reg) * 52'(poly_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg <= prod_next[48:32];
        end
    end

    always_comb
    begin
        bnd = side_reg[RAMP_LAT-2].band;
        ca  = ramp_color(bnd);
        cb  = ramp_color(bnd + 3'd1);
        rgb_next = {blend(ca[23:16], cb[23:16], s_reg),
                    blend(ca[15:8],  cb[15:8],  s_reg),
                    blend(ca[7:0],   cb[7:0],   s_reg)};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            color_reg <= side_reg[RAMP_LAT-2].shown ? {cfg.alpha_level, rgb_next} : '0;
        end
    end

    assign out_valid = vld_reg[RAMP_LAT-1];
    assign shown     = side_reg[RAMP_LAT-1].shown;
    assign grade_out = side_reg[RAMP_LAT-1].grade;
    assign color     = color_reg;

endmodule

### hdl/terrain_slope_heatmap_color.sv
// top level of the terrain slope heatmap color block
//
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  s_tdata: four corner heights
//  m_*       out        m_tvalid/m_tready  m_tdata: grade, argb; m_tuser: shown
//  cfg_*     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
//  one cell per cycle sustained while no output word is held
//  pipeline depth is set by the 64-bit isqrt (8 stages) and the weight divider (4 stages)
//  the whole pipeline advances together; a held output word freezes every stage
//  and drops s_tready in the same cycle, so nothing is lost or repeated
//  reset clears valid bits and restores config defaults; the config port always accepts
`timescale 1ns / 1ps

`include "assert_macros.svh"

module terrain_slope_heatmap_color
    import tshc_pkg::*;
#(
    parameter int TILE_SIZE = TILE_SIZE_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,   // height_x0_z0, height_x1_z0, height_x0_z1, height_x1_z1
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [55:0]  m_tdata,   // grade_value, color_argb
    output logic [0:0]   m_tuser,   // shown
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [23:0]  cfg_data
);

    logic            grade_mode_reg;
    logic [GW-1:0]   min_grade_reg;
    logic [7:0]      alpha_level_reg;
    logic [3:0][GW-1:0] band_edge_reg;

    logic            en;
    logic            g_valid;
    logic [GW-1:0]   g_grade;
    logic            r_valid;
    logic            r_shown;
    logic [GW-1:0]   r_grade;
    logic [CW-1:0]   r_color;
    logic [3:0][HW-1:0] heights;
    tshc_cfg_t       cfg;

    assign cfg_ready = 1'b1;

    // config registers, writes outside the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grade_mode_reg   <= 1'b0;
            min_grade_reg    <= '0;
            alpha_level_reg  <= 8'd140;
            band_edge_reg[0] <= 24'd1280;
            band_edge_reg[1] <= 24'd2560;
            band_edge_reg[2] <= 24'd5120;
            band_edge_reg[3] <= 24'd8960;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_GRADE_MODE:  grade_mode_reg   <= cfg_data[0];
                REG_MIN_GRADE:   min_grade_reg    <= cfg_data;
                REG_ALPHA_LEVEL: alpha_level_reg  <= cfg_data[7:0];
                REG_BAND_EDGE_0: band_edge_reg[0] <= cfg_data;
                REG_BAND_EDGE_1: band_edge_reg[1] <= cfg_data;
                REG_BAND_EDGE_2: band_edge_reg[2] <= cfg_data;
                REG_BAND_EDGE_3: band_edge_reg[3] <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign cfg = '{min_grade: min_grade_reg, alpha_level: alpha_level_reg,
                   band_edge: band_edge_reg};

    // pipeline moves whenever the output word is empty or being taken
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    assign heights[0] = s_tdata[19:0];
    assign heights[1] = s_tdata[39:20];
    assign heights[2] = s_tdata[59:40];
    assign heights[3] = s_tdata[79:60];

    tshc_grade #(
        .TILE_SIZE (TILE_SIZE)
    ) u_grade (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (s_tvalid),
        .heights    (heights),
        .grade_mode (grade_mode_reg),
        .out_valid  (g_valid),
        .grade      (g_grade)
    );

    tshc_ramp u_ramp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (g_valid),
        .grade     (g_grade),
        .cfg       (cfg),
        .out_valid (r_valid),
        .shown     (r_shown),
        .grade_out (r_grade),
        .color     (r_color)
    );

    assign m_tvalid = r_valid;
    assign m_tdata  = {r_color, r_grade};
    assign m_tuser  = r_shown;

    // hidden cells carry a zero color
    `ASSERT_IMPLY(a_hidden_black, clk, rst_n, m_tvalid && !m_tuser[0], m_tdata[55:24] == 32'd0)
    // a held output word blocks the input side
    `ASSERT_IMPLY(a_stall_blocks, clk, rst_n, m_tvalid && !m_tready, !s_tready)
    // a held output word stays in place next cycle
    `ASSERT_NEXT(a_hold_word, clk, rst_n, m_tvalid && !m_tready, m_tvalid)

endmodule

### sim/terrain_slope_heatmap_color_tb.sv
// testbench of the terrain slope heatmap color block: directed table, then random cells
`timescale 1ns / 1ps

module terrain_slope_heatmap_color_tb;
    import tshc_pkg::*;

    typedef struct packed {
        logic          shown;
        logic [23:0]   grade;
        logic [31:0]   argb;
    } cell_out_t;

    // directed row: four heights, optional typed-in expectation
    typedef struct {
        logic [19:0] h00, h10, h01, h11;
        bit          typed;
        cell_out_t   want;
    } cell_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [79:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [55:0]  m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [23:0]  cfg_data = '0;

    // predictor copy of the registers
    logic         pm_mode;
    logic [23:0]  pm_min;
    logic [7:0]   pm_alpha;
    logic [23:0]  pm_edge [4];

    cell_out_t    pending_cells [$];
    int           errors = 0;
    bit           sender_done = 1'b0;
    bit           hold_long = 1'b0;

    terrain_slope_heatmap_color dut (.*);

    always #5 clk = ~clk;

    initial
    begin
        #50ms;
        $display("terrain_slope_heatmap_color_tb: done, errors");
        $finish;
    end

    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'h1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] adiff(input logic [63:0] a, input logic [63:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [16:0] weight_q16(input logic [63:0] e0, input logic [63:0] e1,
                                              input logic [63:0] x);
        logic [63:0] t;
        if (e1 <= e0) return (x >= e1) ? 17'd65536 : 17'd0;
        if (x <= e0) return 17'd0;
        t = ((x - e0) << 16) / (e1 - e0);
        if (t > 65536) t = 65536;
        return 17'((t * t * (3 * 65536 - 2 * t)) >> 32);
    endfunction

    function automatic logic [23:0] mix_rgb(input logic [23:0] a, input logic [23:0] b,
                                           input logic [16:0] s);
        logic [23:0] o;
        int ca, cb, d, r;
        logic [31:0] p;
        o = 0;
        for (int sh = 16; sh >= 0; sh -= 8)
        begin
            ca = (a >> sh) & 8'hFF;
            cb = (b >> sh) & 8'hFF;
            d = cb - ca;
            if (d >= 0)
            begin
                p = d * s;
                r = ca + int'((p + 32768) >> 16);
            end
            else
            begin
                p = (-d) * s;
                r = ca - int'((p + 32768) >> 16);
            end
            if (r < 0) r = 0;
            if (r > 255) r = 255;
            o = o | (24'(r) << sh);
        end
        return o;
    endfunction

    function automatic cell_out_t slope_color(input logic [19:0] a00, input logic [19:0] a10,
                                             input logic [19:0] a01, input logic [19:0] a11);
        logic [63:0] h00, h10, h01, h11, g, c, dx, dz, e0, e1, e2, e3, top, tb;
        logic [23:0] ramp [6];
        logic [23:0] rgb;
        cell_out_t o;
        ramp = '{24'h4CA46D, 24'h9CCB5B, 24'hE9C85B, 24'hE69A43, 24'hD85A3F, 24'h9A3D68};
        h00 = a00; h10 = a10; h01 = a01; h11 = a11;
        if (!pm_mode)
        begin
            g = adiff(h10, h00) * 1600 / 16;
            c = adiff(h11, h10) * 1600 / 16; if (c > g) g = c;
            c = adiff(h11, h01) * 1600 / 16; if (c > g) g = c;
            c = adiff(h01, h00) * 1600 / 16; if (c > g) g = c;
            c = adiff(h11, h00) * 1600 * 46341 / (16 * 65536); if (c > g) g = c;
            c = adiff(h10, h01) * 1600 * 46341 / (16 * 65536); if (c > g) g = c;
        end
        else
        begin
            dx = adiff(h10 + h11, h00 + h01);
            dz = adiff(h01 + h11, h00 + h10);
            g = isqrt((dx * dx + dz * dz) * 640000 / 256);
        end
        if (g > 64'hFFFFFF) g = 64'hFFFFFF;
        o.grade = g[23:0];
        o.shown = (g >= pm_min);
        o.argb = '0;
        if (o.shown)
        begin
            e0 = pm_edge[0]; e1 = pm_edge[1]; e2 = pm_edge[2]; e3 = pm_edge[3];
            top = e3 + 7680;
            tb = e3 * 5 / 2;
            if (tb > top) top = tb;
            if (g <= e0)      rgb = mix_rgb(ramp[0], ramp[1], weight_q16(pm_min, e0, g));
            else if (g <= e1) rgb = mix_rgb(ramp[1], ramp[2], weight_q16(e0, e1, g));
            else if (g <= e2) rgb = mix_rgb(ramp[2], ramp[3], weight_q16(e1, e2, g));
            else if (g <= e3) rgb = mix_rgb(ramp[3], ramp[4], weight_q16(e2, e3, g));
            else              rgb = mix_rgb(ramp[4], ramp[5], weight_q16(e3, top, g));
            o.argb = {pm_alpha, rgb};
        end
        return o;
    endfunction

    // one register write through the config channel, mirrored in the predictor
    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_GRADE_MODE:  pm_mode = val[0];
            REG_MIN_GRADE:   pm_min = val;
            REG_ALPHA_LEVEL: pm_alpha = val[7:0];
            REG_BAND_EDGE_0: pm_edge[0] = val;
            REG_BAND_EDGE_1: pm_edge[1] = val;
            REG_BAND_EDGE_2: pm_edge[2] = val;
            REG_BAND_EDGE_3: pm_edge[3] = val;
            default: ;
        endcase
    endtask

    // offer one cell, wait for acceptance, queue its expectation
    // valid stays high after the handshake so words can follow back to back
    task automatic send_cell(input logic [19:0] a00, input logic [19:0] a10,
                             input logic [19:0] a01, input logic [19:0] a11,
                             input bit typed, input cell_out_t want, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 8) : 0;
        if ($urandom_range(0, 9) < 3) gap = 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {a11, a01, a10, a00};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_cells.push_back(typed ? want : slope_color(a00, a10, a01, a11));
    endtask

    // wait for every queued word, then let the pipe drain
    task automatic drain_all();
        s_tvalid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic logic [19:0] rand_height(input int style);
        case (style)
            0: return 20'($urandom);
            1: return 20'($urandom_range(0, 63));
            2: return $urandom_range(0, 1) ? 20'hFFFFF : 20'h0;
            default: return 20'($urandom_range(500000, 500400));
        endcase
    endfunction

    task automatic random_cells(input int n);
        int st;
        logic [19:0] base;
        cell_out_t z;
        z = '0;
        for (int i = 0; i < n; i++)
        begin
            st = $urandom_range(0, 5);
            if (st >= 3)
            begin
                // gentle slopes around a common level reach every band
                base = 20'($urandom_range(0, 1048000));
                send_cell(base, base + 20'($urandom_range(0, 400)), base + 20'($urandom_range(0, 400)),
                          base + 20'($urandom_range(0, 500)), 1'b0, z, 1'b1);
            end
            else
                send_cell(rand_height(st), rand_height(st), rand_height(st), rand_height(st),
                          1'b0, z, 1'b1);
        end
    endtask

    // directed table: extremes and special cases; flat cells are typed in
    cell_row_t dir_rows [] = '{
        '{20'h0, 20'h0, 20'h0, 20'h0, 1'b1, '{1'b1, 24'd0, {8'd140, 24'h4CA46D}}},
        '{20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 1'b1, '{1'b1, 24'd0, {8'd140, 24'h4CA46D}}},
        '{20'hFFFFF, 20'h0, 20'h0, 20'h0, 1'b0, '0},
        '{20'h0, 20'hFFFFF, 20'h0, 20'h0, 1'b0, '0},
        '{20'h0, 20'h0, 20'hFFFFF, 20'h0, 1'b0, '0},
        '{20'h0, 20'h0, 20'h0, 20'hFFFFF, 1'b0, '0},
        '{20'h0, 20'hFFFFF, 20'hFFFFF, 20'h0, 1'b0, '0},
        '{20'd100, 20'd112, 20'd100, 20'd112, 1'b0, '0},
        '{20'd100, 20'd125, 20'd100, 20'd125, 1'b0, '0},
        '{20'd100, 20'd150, 20'd100, 20'd150, 1'b0, '0},
        '{20'd100, 20'd190, 20'd100, 20'd190, 1'b0, '0},
        '{20'd100, 20'd300, 20'd100, 20'd300, 1'b0, '0},
        '{20'd100, 20'd101, 20'd102, 20'd99, 1'b0, '0},
        '{20'hAAAAA, 20'h55555, 20'h55555, 20'hAAAAA, 1'b0, '0},
        '{20'h55555, 20'hAAAAA, 20'hAAAAA, 20'h55555, 1'b0, '0}
    };

    // stimulus and configuration
    initial
    begin
        cell_out_t z;
        z = '0;
        pm_mode = 1'b0; pm_min = '0; pm_alpha = 8'd140;
        pm_edge[0] = 24'd1280; pm_edge[1] = 24'd2560; pm_edge[2] = 24'd5120; pm_edge[3] = 24'd8960;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_cell(dir_rows[i].h00, dir_rows[i].h10, dir_rows[i].h01, dir_rows[i].h11,
                      dir_rows[i].typed, dir_rows[i].want, 1'b0);
        drain_all();

        // plane mode, with a long receiver hold so the pipe fills and stalls
        write_reg(REG_GRADE_MODE, 24'd1);
        foreach (dir_rows[i])
            if (!dir_rows[i].typed)
                send_cell(dir_rows[i].h00, dir_rows[i].h10, dir_rows[i].h01, dir_rows[i].h11,
                          1'b0, z, 1'b0);
        hold_long = 1'b1;
        random_cells(60);
        hold_long = 1'b0;
        drain_all();

        // min_grade hides most cells, full alpha, out-of-range index ignored
        write_reg(REG_MIN_GRADE, 24'd3000);
        write_reg(REG_ALPHA_LEVEL, 24'hFFFFFF);
        write_reg(3'd7, 24'h123456);
        random_cells(300);
        drain_all();

        // degenerate and non-ascending bands, zero alpha
        write_reg(REG_GRADE_MODE, 24'd0);
        write_reg(REG_MIN_GRADE, 24'd0);
        write_reg(REG_ALPHA_LEVEL, 24'd0);
        write_reg(REG_BAND_EDGE_0, 24'd1);
        write_reg(REG_BAND_EDGE_1, 24'd1);
        write_reg(REG_BAND_EDGE_2, 24'd6000);
        write_reg(REG_BAND_EDGE_3, 24'd3000);
        random_cells(300);
        drain_all();

        // top edges near the saturation point
        write_reg(REG_MIN_GRADE, 24'hFFFFFF);
        write_reg(REG_BAND_EDGE_0, 24'hFFFFFF);
        write_reg(REG_BAND_EDGE_1, 24'hFFFFFF);
        write_reg(REG_BAND_EDGE_2, 24'hFFFFFF);
        write_reg(REG_BAND_EDGE_3, 24'hFFFFFF);
        random_cells(150);
        drain_all();

        // back at default, edge mode, then plane mode
        write_reg(REG_MIN_GRADE, 24'd0);
        write_reg(REG_ALPHA_LEVEL, 24'd140);
        write_reg(REG_BAND_EDGE_0, 24'd1280);
        write_reg(REG_BAND_EDGE_1, 24'd2560);
        write_reg(REG_BAND_EDGE_2, 24'd5120);
        write_reg(REG_BAND_EDGE_3, 24'd8960);
        random_cells(350);
        drain_all();
        write_reg(REG_GRADE_MODE, 24'd1);
        write_reg(REG_MIN_GRADE, 24'd500);
        random_cells(350);
        s_tvalid <= 1'b0;
        sender_done = 1'b1;
    end

    // receiver: random stalls, one long hold while the sender keeps offering
    initial
    begin
        int wait_n;
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_long && !held)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (200) @(posedge clk);
            end
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (wait_n != 0)
            begin
                m_tready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    // checker: compare each accepted word with the oldest expectation
    always @(posedge clk)
    begin
        cell_out_t exp_c;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_cells.size() == 0)
            begin
                $error("output word with nothing expected");
                errors++;
            end
            else
            begin
                exp_c = pending_cells.pop_front();
                if (m_tuser[0] !== exp_c.shown)
                begin
                    $error("shown: expected %0d, got %0d", exp_c.shown, m_tuser[0]);
                    errors++;
                end
                if (m_tdata[23:0] !== exp_c.grade)
                begin
                    $error("grade_value: expected %0d, got %0d", exp_c.grade, m_tdata[23:0]);
                    errors++;
                end
                if (m_tdata[55:24] !== exp_c.argb)
                begin
                    $error("color_argb: expected %h, got %h", exp_c.argb, m_tdata[55:24]);
                    errors++;
                end
            end
        end
    end

    // end of run
    initial
    begin
        wait (sender_done);
        while (pending_cells.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0 && pending_cells.size() == 0)
            $display("terrain_slope_heatmap_color_tb: done, clean");
        else
            $display("terrain_slope_heatmap_color_tb: done, errors");
        $finish;
    end

endmodule
